### rtl/sm_exec_pkg.sv
// ----------------------------------------------------------------------------
// sm_exec_pkg
// Shared types and codes for the stack machine execute step: opcodes,
// error codes, stack cell controls, divider request and sequencer states.
// ----------------------------------------------------------------------------
package sm_exec_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEF = 16;
    localparam int MEM_WORDS_DEF   = 256;

    // opcodes
    localparam logic [7:0] OP_PUSH  = 8'h01;
    localparam logic [7:0] OP_STORE = 8'h02;
    localparam logic [7:0] OP_LOAD  = 8'h03;
    localparam logic [7:0] OP_LT    = 8'h04;
    localparam logic [7:0] OP_GT    = 8'h05;
    localparam logic [7:0] OP_LE    = 8'h06;
    localparam logic [7:0] OP_GE    = 8'h07;
    localparam logic [7:0] OP_EQ    = 8'h08;
    localparam logic [7:0] OP_NE    = 8'h09;
    localparam logic [7:0] OP_ADD   = 8'hA0;
    localparam logic [7:0] OP_SUB   = 8'hA1;
    localparam logic [7:0] OP_DIV   = 8'hA2;
    localparam logic [7:0] OP_MUL   = 8'hA3;
    localparam logic [7:0] OP_OUT   = 8'hA4;
    localparam logic [7:0] OP_JMP   = 8'hA6;
    localparam logic [7:0] OP_JE    = 8'hA7;
    localparam logic [7:0] OP_HALT  = 8'hFF;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OPCODE    = 3'd1;
    localparam logic [2:0] ERR_UNDER     = 3'd2;
    localparam logic [2:0] ERR_OVER      = 3'd3;
    localparam logic [2:0] ERR_DIVZ      = 3'd4;
    localparam logic [2:0] ERR_UNWRITTEN = 3'd5;
    localparam logic [2:0] ERR_ADDR      = 3'd6;

    // what one stack cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_UP,
        CELL_FROM_DOWN
    } cell_op_t;

    // divider request
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_POP2,
        S_LOAD,
        S_DIV
    } state_t;

endpackage

### rtl/sm_exec_cell.sv
// ----------------------------------------------------------------------------
// sm_exec_cell
// One word of the operand stack; takes the word of its upper or lower
// neighbor, or holds.
// ----------------------------------------------------------------------------
module sm_exec_cell
    import sm_exec_pkg::*;
(
    input  logic        clk,
    input  cell_op_t    op,
    input  logic [15:0] from_up,
    input  logic [15:0] from_down,
    output logic [15:0] word
);

    logic [15:0] word_reg;
    logic [15:0] word_next;

    // neighbor select
    always_comb
    begin
        case (op)
            CELL_FROM_UP:   word_next = from_up;
            CELL_FROM_DOWN: word_next = from_down;
            default:        word_next = word_reg;
        endcase
    end

    // payload register
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

### rtl/sm_exec_div.sv
// ----------------------------------------------------------------------------
// sm_exec_div
// Signed 16-bit truncating divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sm_exec_div
    import sm_exec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        busy,
    output logic [15:0] quotient
);

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic [17:0] trial;

    // restoring step
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        trial     = {1'b0, rem_reg, quo_reg[15]} - {2'b00, dsr_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd16;
            rem_next  = '0;
            quo_next  = req.dividend[15] ? (16'd0 - req.dividend) : req.dividend;
            dsr_next  = req.divisor[15] ? (16'd0 - req.divisor) : req.divisor;
            neg_next  = req.dividend[15] ^ req.divisor[15];
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[14:0], quo_reg[15]};
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (16'd0 - quo_reg) : quo_reg;

endmodule

### rtl/stack_machine_execute_step.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_step
// Executes one fetched instruction per item on a stack of shifting cells.
// ----------------------------------------------------------------------------
// One item is taken at a time. Most opcodes are accepted in S_IDLE and
// finish in S_EXEC; STORE and LOAD pass through a further state (S_POP2 for
// the second pop, S_LOAD for the registered memory read), and DIV waits in
// S_DIV until the divider is done. After reset the written marks of data
// memory are cleared in a pass over all MEM_WORDS words, during which no
// item is taken; configuration writes are taken at any time.
module stack_machine_execute_step
    import sm_exec_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int MEM_WORDS   = MEM_WORDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         func,
    input  logic [15:0]        imm_first,
    input  logic [15:0]        imm_second,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        next_addr,
    output logic               print_valid,
    output logic signed [15:0] print_value,
    output logic               stopped,
    output logic [2:0]         error_code
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    state_t      state_reg, state_next;
    logic [15:0] plen_reg;
    logic [15:0] ip_reg, ip_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        stop_reg, stop_next;
    logic [2:0]  fault_reg, fault_next;
    logic [7:0]  func_reg;
    logic [15:0] imm1_reg, imm2_reg;
    logic [AW-1:0] clr_reg, clr_next;

    logic        out_valid_reg;
    logic [15:0] out_addr_reg;
    logic        out_pv_reg;
    logic [15:0] out_pval_reg;
    logic        out_stop_reg;
    logic [2:0]  out_err_reg;

    logic [15:0] mem_words [MEM_WORDS];
    logic        mem_mark [MEM_WORDS];
    logic [15:0] rd_word_reg;
    logic        rd_mark_reg;
    logic        mem_we;

    logic [15:0] cell_q [STACK_DEPTH];
    cell_op_t    op_top, op_rest;
    logic [15:0] cell_in;
    logic [15:0] top_w, sec_w;

    div_req_t    div_req;
    logic        div_busy;
    logic [15:0] div_q;

    logic        out_free, fin, keep, pv;
    logic [2:0]  err;
    logic [15:0] nxt, pval, alu;
    logic        addr_bad;

    assign top_w    = cell_q[0];
    assign sec_w    = cell_q[1];
    assign out_free = !out_valid_reg || !out_stall;
    assign addr_bad = {1'b0, top_w} >= 17'(MEM_WORDS);

    // operand stack as a row of cells, top of stack in cell zero
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic [15:0] up_w, down_w;
            cell_op_t    c_op;
            if (gi == 0)
            begin : g_top
                assign up_w = cell_in;
                assign c_op = op_top;
            end
            else
            begin : g_mid
                assign up_w = cell_q[gi-1];
                assign c_op = op_rest;
            end
            if (gi == STACK_DEPTH - 1)
            begin : g_last
                assign down_w = '0;
            end
            else
            begin : g_more
                assign down_w = cell_q[gi+1];
            end
            sm_exec_cell u_cell (
                .clk       (clk),
                .op        (c_op),
                .from_up   (up_w),
                .from_down (down_w),
                .word      (cell_q[gi])
            );
        end
    endgenerate

    // divider
    sm_exec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // combinational binary ops
    always_comb
    begin
        case (func_reg)
            OP_LT:   alu = {15'd0, $signed(sec_w) <  $signed(top_w)};
            OP_GT:   alu = {15'd0, $signed(sec_w) >  $signed(top_w)};
            OP_LE:   alu = {15'd0, $signed(sec_w) <= $signed(top_w)};
            OP_GE:   alu = {15'd0, $signed(sec_w) >= $signed(top_w)};
            OP_EQ:   alu = {15'd0, sec_w == top_w};
            OP_NE:   alu = {15'd0, sec_w != top_w};
            OP_ADD:  alu = sec_w + top_w;
            OP_SUB:  alu = sec_w - top_w;
            OP_MUL:  alu = 16'(32'(sec_w) * 32'(top_w));
            default: alu = '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ip_next    = ip_reg;
        cnt_next   = cnt_reg;
        stop_next  = stop_reg;
        fault_next = fault_reg;
        op_top     = CELL_HOLD;
        op_rest    = CELL_HOLD;
        cell_in    = imm1_reg;
        mem_we     = 1'b0;
        div_req    = '{start: 1'b0, dividend: sec_w, divisor: top_w};
        fin        = 1'b0;
        keep       = 1'b0;
        err        = ERR_NONE;
        nxt        = ip_reg + 16'd1;
        pv         = 1'b0;
        pval       = '0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MEM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    fin = 1'b1;
                    if (stop_reg)
                    begin
                        keep = 1'b1;
                    end
                    else if (ip_reg >= plen_reg)
                    begin
                        keep      = 1'b1;
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        case (func_reg)
                            OP_HALT:
                            begin
                                stop_next = 1'b1;
                            end
                            OP_PUSH:
                            begin
                                nxt = ip_reg + 16'd3;
                                if (cnt_reg == CW'(STACK_DEPTH))
                                begin
                                    err = ERR_OVER;
                                end
                                else
                                begin
                                    op_top   = CELL_FROM_UP;
                                    op_rest  = CELL_FROM_UP;
                                    cnt_next = cnt_reg + CW'(1);
                                end
                            end
                            OP_STORE:
                            begin
                                if (cnt_reg < CW'(2))
                                begin
                                    err = ERR_UNDER;
                                end
                                else if (addr_bad)
                                begin
                                    err = ERR_ADDR;
                                end
                                else
                                begin
                                    fin        = 1'b0;
                                    mem_we     = 1'b1;
                                    op_top     = CELL_FROM_DOWN;
                                    op_rest    = CELL_FROM_DOWN;
                                    cnt_next   = cnt_reg - CW'(1);
                                    state_next = S_POP2;
                                end
                            end
                            OP_LOAD:
                            begin
                                if (cnt_reg == '0)
                                begin
                                    err = ERR_UNDER;
                                end
                                else if (addr_bad)
                                begin
                                    err = ERR_ADDR;
                                end
                                else
                                begin
                                    fin        = 1'b0;
                                    state_next = S_LOAD;
                                end
                            end
                            OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE,
                            OP_ADD, OP_SUB, OP_MUL:
                            begin
                                if (cnt_reg < CW'(2))
                                begin
                                    err = ERR_UNDER;
                                end
                                else
                                begin
                                    cell_in  = alu;
                                    op_top   = CELL_FROM_UP;
                                    op_rest  = CELL_FROM_DOWN;
                                    cnt_next = cnt_reg - CW'(1);
                                end
                            end
                            OP_DIV:
                            begin
                                if (cnt_reg < CW'(2))
                                begin
                                    err = ERR_UNDER;
                                end
                                else if (top_w == '0)
                                begin
                                    err = ERR_DIVZ;
                                end
                                else
                                begin
                                    fin           = 1'b0;
                                    div_req.start = 1'b1;
                                    state_next    = S_DIV;
                                end
                            end
                            OP_OUT:
                            begin
                                if (cnt_reg == '0)
                                begin
                                    err = ERR_UNDER;
                                end
                                else
                                begin
                                    pv       = 1'b1;
                                    pval     = top_w;
                                    op_top   = CELL_FROM_DOWN;
                                    op_rest  = CELL_FROM_DOWN;
                                    cnt_next = cnt_reg - CW'(1);
                                end
                            end
                            OP_JMP:
                            begin
                                nxt = imm1_reg;
                            end
                            OP_JE:
                            begin
                                if (cnt_reg == '0)
                                begin
                                    err = ERR_UNDER;
                                end
                                else
                                begin
                                    nxt      = (top_w != '0) ? imm1_reg : imm2_reg;
                                    op_top   = CELL_FROM_DOWN;
                                    op_rest  = CELL_FROM_DOWN;
                                    cnt_next = cnt_reg - CW'(1);
                                end
                            end
                            default:
                            begin
                                err = ERR_OPCODE;
                            end
                        endcase
                    end
                end
            end
            S_POP2:
            begin
                if (out_free)
                begin
                    fin      = 1'b1;
                    op_top   = CELL_FROM_DOWN;
                    op_rest  = CELL_FROM_DOWN;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    fin = 1'b1;
                    if (!rd_mark_reg)
                    begin
                        err = ERR_UNWRITTEN;
                    end
                    else
                    begin
                        cell_in = rd_word_reg;
                        op_top  = CELL_FROM_UP;
                    end
                end
            end
            S_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    fin      = 1'b1;
                    cell_in  = div_q;
                    op_top   = CELL_FROM_UP;
                    op_rest  = CELL_FROM_DOWN;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // commit of a finished instruction
        if (fin)
        begin
            state_next = S_IDLE;
            if (!keep)
            begin
                if (err != ERR_NONE)
                begin
                    stop_next  = 1'b1;
                    fault_next = err;
                end
                else
                begin
                    ip_next = nxt;
                    if (nxt >= plen_reg)
                    begin
                        stop_next = 1'b1;
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            plen_reg      <= '0;
            ip_reg        <= '0;
            cnt_reg       <= '0;
            stop_reg      <= 1'b0;
            fault_reg     <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ip_reg    <= ip_next;
            cnt_reg   <= cnt_next;
            stop_reg  <= stop_next;
            fault_reg <= fault_next;
            if (cfg_wr_en)
            begin
                plen_reg <= cfg_wr_data;
            end
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= func;
            imm1_reg <= imm_first;
            imm2_reg <= imm_second;
        end
        if (fin)
        begin
            out_addr_reg <= ip_next;
            out_pv_reg   <= pv;
            out_pval_reg <= pval;
            out_stop_reg <= stop_next;
            out_err_reg  <= fault_next;
        end
    end

    // data memory and written marks, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_mark[clr_reg] <= 1'b0;
        end
        else if (mem_we)
        begin
            mem_mark[top_w[AW-1:0]]  <= 1'b1;
            mem_words[top_w[AW-1:0]] <= sec_w;
        end
        rd_word_reg <= mem_words[top_w[AW-1:0]];
        rd_mark_reg <= mem_mark[top_w[AW-1:0]];
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign next_addr   = out_addr_reg;
    assign print_valid = out_pv_reg;
    assign print_value = out_pval_reg;
    assign stopped     = out_stop_reg;
    assign error_code  = out_err_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |=> stop_reg)
        else $error("stop flag cleared");

    a_fault_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (fault_reg != ERR_NONE) |-> stop_reg)
        else $error("fault without stop");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider busy outside divide");

endmodule
